### sv/psd_pkg.sv
// Shared types, sizes and result codes for the port scan detector.
// No dependencies; imported by every module of the block.
package psd_pkg;

  localparam int MAX_SOURCES      = 256;
  localparam int PORTS_PER_SOURCE = 1024;
  localparam int SLOT_W           = $clog2(MAX_SOURCES);
  localparam int PIDX_W           = $clog2(PORTS_PER_SOURCE);
  localparam int CNT_W            = 11;
  localparam int THR_RESET        = 15;
  localparam int WIN_RESET        = 10;

  // Register indexes of the configuration port
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_WINDOW    = 1'b1;

  typedef enum logic [1:0] {
    ST_NEW        = 2'd0,
    ST_DUP        = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_STORE_FULL = 2'd3
  } status_t;

  // How the front end resolved the source
  typedef enum logic [1:0] {
    K_HIT,
    K_NEW,
    K_FULL
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic [15:0]        port;
    logic [31:0]        now;
  } q_item_t;

  typedef struct packed {
    logic [31:0]      ws;
    logic [CNT_W-1:0] total;
    logic             ag;
  } meta_t;

  typedef enum logic [1:0] {F_IDLE, F_SEARCH, F_PUSH} fstate_t;
  typedef enum logic [1:0] {B_IDLE, B_META, B_SEARCH, B_DONE} bstate_t;

endpackage

### sv/port_scan_detector.sv
// Port scan detector top level: configuration registers, front end, queue, back end.
// The front end searches the slots in use and the back end the stored ports of the
// source; the queue lets the front end take a new item while the back end works.
// Reset clears control, slot count and config registers; tables hold no reset value.
module port_scan_detector
  import psd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_source_address,
  input  logic [15:0] in_dest_port,
  input  logic [31:0] in_now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_alert,
  output logic [1:0]  out_status,
  output logic [10:0] out_distinct_ports,
  output logic [7:0]  out_source_slot,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [CNT_W-1:0] thr_r;
  logic [15:0]      win_r;
  logic             q_push, q_pop, q_full, q_empty;
  q_item_t          q_in, q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= CNT_W'(THR_RESET);
      win_r <= 16'(WIN_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thr_r <= cfg_wdata[CNT_W-1:0];
        CFG_WINDOW:    win_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  psd_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_source_address, .in_dest_port,
    .in_now_seconds, .q_full, .q_push, .q_item(q_in)
  );

  psd_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_item(q_in), .pop(q_pop), .head(q_head),
    .full(q_full), .empty(q_empty)
  );

  psd_back u_back (
    .clk, .rst_n, .q_empty, .q_head, .q_pop, .thr_limit(thr_r),
    .window_seconds(win_r), .out_valid, .out_ready, .out_alert, .out_status,
    .out_distinct_ports, .out_source_slot
  );

  // An alert only comes with a newly counted port or with a full port store
  a_alert_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alert |-> out_status == ST_NEW || out_status == ST_STORE_FULL)
    else $error("alert with wrong status");

  // Ignored sources report zero fields
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_TABLE_FULL |->
      out_distinct_ports == '0 && out_source_slot == '0 && !out_alert)
    else $error("table full item with non-zero fields");

  // A newly recorded port leaves a non-zero count
  a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NEW |-> out_distinct_ports != '0)
    else $error("new port with zero count");

endmodule

### sv/psd_front.sv
// Front end: accepts items and finds or allocates the source slot.
// Owns the source address table; depends on psd_pkg.
module psd_front
  import psd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_source_address,
  input  logic [15:0] in_dest_port,
  input  logic [31:0] in_now_seconds,
  input  logic        q_full,
  output logic        q_push,
  output q_item_t     q_item
);

  logic [31:0] slot_mem [MAX_SOURCES];
  logic [31:0] rd_r;

  fstate_t           state_r, state_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic [15:0]       port_r, port_nxt;
  logic [31:0]       now_r, now_nxt;
  logic [SLOT_W:0]   idx_r, idx_nxt;
  logic [SLOT_W:0]   used_r, used_nxt;
  logic              pend_r, pend_nxt;
  logic [SLOT_W-1:0] pidx_r, pidx_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  kind_t             kind_r, kind_nxt;
  logic              issue, wr_en;

  // Address table: one registered read, one write
  always_ff @(posedge clk) begin
    if (issue) rd_r <= slot_mem[idx_r[SLOT_W-1:0]];
    if (wr_en) slot_mem[used_r[SLOT_W-1:0]] <= addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      used_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      pend_r  <= pend_nxt;
    end
    addr_r <= addr_nxt;
    port_r <= port_nxt;
    now_r  <= now_nxt;
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
    slot_r <= slot_nxt;
    kind_r <= kind_nxt;
  end

  // Search runs one slot a cycle, each compare in the cycle after its read
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    port_nxt  = port_r;
    now_nxt   = now_r;
    idx_nxt   = idx_r;
    used_nxt  = used_r;
    pend_nxt  = pend_r;
    pidx_nxt  = pidx_r;
    slot_nxt  = slot_r;
    kind_nxt  = kind_r;
    issue     = 1'b0;
    wr_en     = 1'b0;
    q_push    = 1'b0;
    in_ready  = (state_r == F_IDLE);
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          addr_nxt  = in_source_address;
          port_nxt  = in_dest_port;
          now_nxt   = in_now_seconds;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = F_SEARCH;
        end
      end
      F_SEARCH: begin
        if (pend_r && rd_r == addr_r) begin
          kind_nxt  = K_HIT;
          slot_nxt  = pidx_r;
          pend_nxt  = 1'b0;
          state_nxt = F_PUSH;
        end else if (!pend_r && idx_r >= used_r) begin
          if (used_r == (SLOT_W+1)'(MAX_SOURCES)) begin
            kind_nxt = K_FULL;
            slot_nxt = '0;
          end else begin
            kind_nxt = K_NEW;
            slot_nxt = used_r[SLOT_W-1:0];
          end
          state_nxt = F_PUSH;
        end else begin
          issue    = (idx_r < used_r);
          pend_nxt = issue;
          pidx_nxt = idx_r[SLOT_W-1:0];
          idx_nxt  = idx_r + (SLOT_W+1)'(issue);
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push = 1'b1;
          if (kind_r == K_NEW) begin
            wr_en    = 1'b1;
            used_nxt = used_r + 1'b1;
          end
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign q_item = '{kind: kind_r, slot: slot_r, port: port_r, now: now_r};

endmodule

### sv/psd_queue.sv
// Two-entry item queue between front and back end.
// Depends on psd_pkg for the item type.
module psd_queue
  import psd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  input  logic    pop,
  output q_item_t head,
  output logic    full,
  output logic    empty
);

  q_item_t    ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign head  = ent_r[rp_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

endmodule

### sv/psd_back.sv
// Back end: window check, distinct port search and update, result register.
// Owns the per-slot window records and the port store; depends on psd_pkg.
module psd_back
  import psd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  q_item_t          q_head,
  output logic             q_pop,
  input  logic [CNT_W-1:0] thr_limit,
  input  logic [15:0]      window_seconds,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_alert,
  output logic [1:0]       out_status,
  output logic [CNT_W-1:0] out_distinct_ports,
  output logic [SLOT_W-1:0] out_source_slot
);

  localparam logic [CNT_W-1:0] PPS = CNT_W'(PORTS_PER_SOURCE);

  meta_t       meta_mem [MAX_SOURCES];
  logic [15:0] port_mem [MAX_SOURCES*PORTS_PER_SOURCE];
  meta_t       meta_rd_r;
  logic [15:0] ps_rd_r;

  bstate_t          state_r, state_nxt;
  q_item_t          item_r, item_nxt;
  meta_t            rec_r, rec_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  status_t          st_r, st_nxt;
  logic             al_r, al_nxt;
  logic             ov_r, ov_nxt;
  logic             oal_r;
  status_t          ost_r;
  logic [CNT_W-1:0] ocnt_r;
  logic [SLOT_W-1:0] oslot_r;
  logic             issue, ps_we, meta_we, load;
  logic [CNT_W-1:0] new_cnt;
  logic [31:0]      age;

  // Window records and port store, registered reads
  always_ff @(posedge clk) begin
    if (q_pop) meta_rd_r <= meta_mem[q_head.slot];
    if (meta_we) meta_mem[item_r.slot] <= rec_r;
    if (issue) ps_rd_r <= port_mem[{item_r.slot, idx_r[PIDX_W-1:0]}];
    if (ps_we) port_mem[{item_r.slot, cnt_r[PIDX_W-1:0]}] <= item_r.port;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
    item_r <= item_nxt;
    rec_r  <= rec_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    st_r   <= st_nxt;
    al_r   <= al_nxt;
    if (load) begin
      oal_r   <= al_r;
      ost_r   <= st_r;
      ocnt_r  <= cnt_r;
      oslot_r <= item_r.slot;
    end
  end

  assign age = item_r.now - meta_rd_r.ws;

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    rec_nxt   = rec_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    st_nxt    = st_r;
    al_nxt    = al_r;
    ov_nxt    = ov_r & ~out_ready;
    q_pop     = 1'b0;
    issue     = 1'b0;
    ps_we     = 1'b0;
    meta_we   = 1'b0;
    load      = 1'b0;
    new_cnt   = cnt_r + 1'b1;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          item_nxt = q_head;
          if (q_head.kind == K_FULL) begin
            st_nxt    = ST_TABLE_FULL;
            al_nxt    = 1'b0;
            cnt_nxt   = '0;
            state_nxt = B_DONE;
          end else begin
            state_nxt = B_META;
          end
        end
      end
      // New source or expired window restarts the record
      B_META: begin
        if (item_r.kind == K_NEW || age > {16'd0, window_seconds}) begin
          rec_nxt = '{ws: item_r.now, total: '0, ag: 1'b0};
        end else begin
          rec_nxt = meta_rd_r;
        end
        cnt_nxt   = (rec_nxt.total > PPS) ? PPS : rec_nxt.total;
        idx_nxt   = '0;
        pend_nxt  = 1'b0;
        state_nxt = B_SEARCH;
      end
      // One stored port a cycle, each compare in the cycle after its read
      B_SEARCH: begin
        if (pend_r && ps_rd_r == item_r.port) begin
          st_nxt    = ST_DUP;
          al_nxt    = 1'b0;
          pend_nxt  = 1'b0;
          state_nxt = B_DONE;
        end else if (!pend_r && idx_r >= cnt_r) begin
          if (cnt_r < PPS) begin
            ps_we         = 1'b1;
            cnt_nxt       = new_cnt;
            rec_nxt.total = new_cnt;
            st_nxt        = ST_NEW;
          end else begin
            st_nxt = ST_STORE_FULL;
          end
          al_nxt = 1'b0;
          if (!rec_r.ag && cnt_nxt > thr_limit) begin
            rec_nxt.ag = 1'b1;
            al_nxt     = 1'b1;
          end
          state_nxt = B_DONE;
        end else begin
          issue    = (idx_r < cnt_r);
          pend_nxt = issue;
          idx_nxt  = idx_r + CNT_W'(issue);
        end
      end
      B_DONE: begin
        if (!ov_r || out_ready) begin
          load      = 1'b1;
          ov_nxt    = 1'b1;
          meta_we   = (item_r.kind != K_FULL);
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign out_valid          = ov_r;
  assign out_alert          = oal_r;
  assign out_status         = ost_r;
  assign out_distinct_ports = ocnt_r;
  assign out_source_slot    = oslot_r;

endmodule

### test/port_scan_detector_checker.sv
// Checker for the port scan detector: watches the item, result and config ports,
// predicts each result from its own copy of the source table and compares.
// Depends on psd_pkg for sizes, register indexes and status codes.
module port_scan_detector_checker
  import psd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_source_address,
  input  logic [15:0] in_dest_port,
  input  logic [31:0] in_now_seconds,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_alert,
  input  logic [1:0]  out_status,
  input  logic [10:0] out_distinct_ports,
  input  logic [7:0]  out_source_slot,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        alert;
    status_t     status;
    logic [10:0] ports;
    logic [7:0]  slot;
  } verdict_t;

  // Shadow of the detector's registers and tables
  logic [10:0] threshold;
  logic [15:0] window;
  logic [31:0] src_addr   [MAX_SOURCES];
  logic [31:0] win_begin  [MAX_SOURCES];
  int          kept_ports [MAX_SOURCES];
  logic        alerted    [MAX_SOURCES];
  logic [15:0] seen_ports [MAX_SOURCES][PORTS_PER_SOURCE];
  int          sources;

  verdict_t owed_verdicts[$];

  assign results_owed = owed_verdicts.size();

  function automatic verdict_t scan_verdict(logic [31:0] addr, logic [15:0] port,
                                            logic [31:0] now);
    verdict_t v;
    int       s;
    int       n;
    logic     hit;
    hit = 1'b0;
    s = 0;
    v.alert = 1'b0;
    v.ports = '0;
    v.slot  = '0;
    for (int i = 0; i < sources; i++) begin
      if (!hit && src_addr[i] == addr) begin
        hit = 1'b1;
        s = i;
      end
    end
    // unknown source: allocate, or ignore when the table is full
    if (!hit) begin
      if (sources >= MAX_SOURCES) begin
        v.status = ST_TABLE_FULL;
        return v;
      end
      s = sources;
      sources++;
      src_addr[s]   = addr;
      kept_ports[s] = 0;
      win_begin[s]  = now;
      alerted[s]    = 1'b0;
    end
    // expired window restarts the record (difference wraps)
    if (32'(now - win_begin[s]) > {16'd0, window}) begin
      kept_ports[s] = 0;
      win_begin[s]  = now;
      alerted[s]    = 1'b0;
    end
    n = kept_ports[s];
    v.slot = s[7:0];
    for (int i = 0; i < n; i++) begin
      if (seen_ports[s][i] == port) begin
        v.status = ST_DUP;
        v.ports  = n[10:0];
        return v;
      end
    end
    if (n < PORTS_PER_SOURCE) begin
      seen_ports[s][n] = port;
      n++;
      kept_ports[s] = n;
      v.status = ST_NEW;
    end else begin
      v.status = ST_STORE_FULL;
    end
    if (!alerted[s] && n > int'(threshold)) begin
      alerted[s] = 1'b1;
      v.alert = 1'b1;
    end
    v.ports = n[10:0];
    return v;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  // Track config, predict on accepted items, compare accepted results
  always @(posedge clk) begin
    verdict_t v;
    if (!rst_n) begin
      threshold <= 11'(THR_RESET);
      window    <= 16'(WIN_RESET);
      sources = 0;
      owed_verdicts.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_THRESHOLD) threshold <= cfg_wdata[10:0];
        else window <= cfg_wdata;
      end
      if (in_valid && in_ready)
        owed_verdicts.push_back(scan_verdict(in_source_address, in_dest_port,
                                             in_now_seconds));
      if (out_valid && out_ready) begin
        if (owed_verdicts.size() == 0) begin
          $display("%0t: result with no item outstanding", $realtime);
          fail_count++;
        end else begin
          v = owed_verdicts.pop_front();
          if (out_alert !== v.alert) report("alert", 32'(out_alert), 32'(v.alert));
          if (out_status !== v.status) report("status", 32'(out_status), 32'(v.status));
          if (out_distinct_ports !== v.ports)
            report("distinct_ports", 32'(out_distinct_ports), 32'(v.ports));
          if (out_source_slot !== v.slot)
            report("source_slot", 32'(out_source_slot), 32'(v.slot));
        end
      end
    end
  end

endmodule

### test/port_scan_detector_tb.sv
// Top of the port scan detector testbench: clock, reset, item and config stimulus.
// Depends on psd_pkg, port_scan_detector and port_scan_detector_checker.
module port_scan_detector_tb;
  import psd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 30_000_000;
  localparam int POOL        = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_source_address;
  logic [15:0] in_dest_port;
  logic [31:0] in_now_seconds;
  logic        out_valid;
  logic        out_ready;
  logic        out_alert;
  logic [1:0]  out_status;
  logic [10:0] out_distinct_ports;
  logic [7:0]  out_source_slot;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          results_owed;

  int          idle_mode;     // 0 none, 1 sender, 2 receiver, 3 both lightly
  int          hold_cycles;   // long receiver hold-off request
  int          cycles;
  logic [31:0] clock_now;
  logic [31:0] addr_pool [POOL];

  port_scan_detector uut (.*);

  port_scan_detector_checker checker_i (.*);

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls per idle mode, plus the long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (idle_mode == 2) out_ready <= ($urandom_range(0, 99) >= 61);
    else if (idle_mode == 3) out_ready <= ($urandom_range(0, 99) >= 7);
    else out_ready <= 1'b1;
  end

  // One register write, with the enable low again before return so writes never share a time step
  task automatic cfg_write(logic idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one item and wait for it to be taken, then maybe idle
  task automatic send_packet(logic [31:0] addr, logic [15:0] port, logic [31:0] now);
    logic taken;
    int   gap;
    in_valid          <= 1'b1;
    in_source_address <= addr;
    in_dest_port      <= port;
    in_now_seconds    <= now;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    gap = 0;
    if (idle_mode == 1) while ($urandom_range(0, 99) < 61) gap++;
    else if (idle_mode == 3) while ($urandom_range(0, 99) < 7) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Quiesce before touching the registers
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Random traffic: a working set of sources, small port sets, time creeping on with rare jumps
  task automatic random_traffic(int n, int pool_span);
    logic [15:0] port;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 4) clock_now = $urandom();
      else clock_now = clock_now + $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) port = 16'($urandom());
      else port = 16'($urandom_range(0, 30));
      send_packet(addr_pool[$urandom_range(0, pool_span - 1)], port, clock_now);
    end
  endtask

  initial begin
    logic [15:0] thr_pick [6];
    logic [15:0] win_pick [5];
    thr_pick = '{16'd0, 16'd1, 16'd4, 16'd15, 16'd1024, 16'd2047};
    win_pick = '{16'd0, 16'd3, 16'd10, 16'd40, 16'd65535};
    cycles            = 0;
    idle_mode         = 0;
    hold_cycles       = 0;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_source_address = '0;
    in_dest_port      = '0;
    in_now_seconds    = '0;
    out_ready         = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = CFG_THRESHOLD;
    cfg_wdata         = '0;
    for (int i = 0; i < POOL; i++) addr_pool[i] = $urandom();
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: port extremes, duplicate, expiry, time wrap
    send_packet(32'h0, 16'h0000, 32'd100);
    send_packet(32'h0, 16'hFFFF, 32'd101);
    send_packet(32'h0, 16'hFFFF, 32'd102);
    send_packet(32'hFFFF_FFFF, 16'h1234, 32'hFFFF_FFFF);
    send_packet(32'hFFFF_FFFF, 16'h4321, 32'd3);
    send_packet(32'h0, 16'h0000, 32'd111);
    send_packet(32'h0, 16'h0001, 32'd50);
    for (int p = 2; p < 18; p++) send_packet(32'h0, 16'(p), 32'd50);
    drain();

    // Zero threshold and zero window: first port alerts, next second restarts
    cfg_write(CFG_THRESHOLD, 16'd0);
    cfg_write(CFG_WINDOW, 16'd0);
    send_packet(32'hA5A5_5A5A, 16'd80, 32'd7);
    send_packet(32'hA5A5_5A5A, 16'd81, 32'd7);
    send_packet(32'hA5A5_5A5A, 16'd80, 32'd8);
    drain();

    // Fill one source's port store past capacity in one long window
    cfg_write(CFG_THRESHOLD, 16'd1023);
    cfg_write(CFG_WINDOW, 16'd65535);
    for (int p = 0; p < PORTS_PER_SOURCE + 4; p++)
      send_packet(32'h0BAD_F00D, 16'(p * 61), 32'd9);
    send_packet(32'h0BAD_F00D, 16'd0, 32'd9);
    drain();

    // Random phases across idle modes and register settings
    clock_now = 32'd1000;
    for (int ph = 0; ph < 8; ph++) begin
      idle_mode = ph % 4;
      cfg_write(CFG_THRESHOLD, thr_pick[$urandom_range(0, 5)]);
      cfg_write(CFG_WINDOW, win_pick[$urandom_range(0, 4)]);
      if (ph == 5) hold_cycles = 3000;
      if (ph == 6)
        for (int i = 0; i < POOL; i++) send_packet(addr_pool[i], 16'($urandom()), clock_now);
      random_traffic(50, (ph < 4) ? 40 : POOL);
      drain();
    end

    repeat (1500) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
sv/psd_pkg.sv
sv/psd_front.sv
sv/psd_queue.sv
sv/psd_back.sv
sv/port_scan_detector.sv
test/port_scan_detector_checker.sv
test/port_scan_detector_tb.sv
